/* rtl/mced_pkg.sv */
package mced_pkg;

    localparam int FLOORS_DEF = 16;
    localparam int CARS_DEF   = 4;

    localparam int FLOOR_W = 4;
    localparam int CAR_W   = 2;
    localparam int KIND_W  = 2;
    localparam int DIR_W   = 2;
    localparam int TIME_W  = 4;

    localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HALL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DEST = 2'd2;

    localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
    localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
    localparam logic [DIR_W-1:0] DIR_DN   = 2'd2;

    localparam logic [TIME_W-1:0] DWELL_TICKS_RST = 4'd3;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FLOOR_W-1:0] floor;
        logic               call_dir;
        logic [CAR_W-1:0]   car;
    } ev_t;

    typedef struct packed {
        logic [CAR_W-1:0]   car_index;
        logic [FLOOR_W-1:0] car_floor_out;
        logic [DIR_W-1:0]   car_heading;
        logic               loading_busy;
        logic               unloading_busy;
        logic               last_car;
    } st_t;

    typedef struct packed {
        logic event_apply;
        logic decide;
        logic move;
    } cmd_t;

endpackage

/* rtl/mced_if.sv */
interface mced_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/mced_ctrl.sv */
module mced_ctrl
    import mced_pkg::*;
#(
    parameter int CARS = CARS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [KIND_W-1:0]         in_kind,
    output logic                      in_ready,
    output logic                      out_valid,
    input  logic                      out_ready,
    output cmd_t                      cmd,
    output logic [$clog2(CARS+1)-1:0] car_sel
);

    localparam int CW = $clog2(CARS + 1);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DEC  = 2'd1;
    localparam logic [1:0] S_MOVE = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign car_sel   = cnt_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.event_apply = 1'b1;
                    cnt_next = '0;
                    if (in_kind == KIND_TICK)
                        state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                cmd.decide = 1'b1;
                if (cnt_reg == CW'(CARS - 1))
                    state_next = S_MOVE;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_MOVE:
            begin
                cmd.move   = 1'b1;
                cnt_next   = '0;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    if (cnt_reg == CW'(CARS - 1))
                        state_next = S_IDLE;
                    else
                        cnt_next = cnt_reg + 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

`ifndef SYNTH
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < CW'(CARS)) else $error("car counter out of range");
    a_move_then_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.move |=> out_valid) else $error("no output after move");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !in_ready) else $error("ready while busy");
`endif

endmodule

/* rtl/mced_dp.sv */
module mced_dp
    import mced_pkg::*;
#(
    parameter int FLOORS = FLOORS_DEF,
    parameter int CARS   = CARS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [TIME_W-1:0]         cfg_data,
    input  ev_t                       ev,
    input  cmd_t                      cmd,
    input  logic [$clog2(CARS+1)-1:0] car_sel,
    output st_t                       st
);

    localparam int CW = $clog2(CARS + 1);
    localparam int FW = $clog2(FLOORS);
    localparam int AW = (CARS > 1) ? $clog2(CARS) : 1;

    logic [TIME_W-1:0] lt_reg;
    logic [FLOORS-1:0] up_reg, dn_reg;
    logic [FLOORS-1:0] dst_reg [CARS];
    logic [FW-1:0]     pos_reg [CARS];
    logic [DIR_W-1:0]  dir_reg [CARS];
    logic [TIME_W-1:0] ldc_reg [CARS];
    logic [TIME_W-1:0] ulc_reg [CARS];

    logic [AW-1:0]     c;
    logic [FW-1:0]     cur;
    logic [DIR_W-1:0]  d0;
    logic [TIME_W-1:0] ldc, ulc;
    logic [FLOORS-1:0] dst, req, mabove, mbelow, ra, rb;
    logic              dest_above, dest_below, req_above, req_below;
    logic [FW-1:0]     near_hi, near_lo;
    logic              bt_up, bt_dn, opp_up, opp_dn;
    logic [DIR_W-1:0]  d_new;
    logic              clr_dst, clr_up, clr_dn, arm_ul, arm_ld;

    assign c   = AW'(car_sel);
    assign cur = pos_reg[c];
    assign dst = dst_reg[c];
    assign req = up_reg | dn_reg;
    assign ldc = (ldc_reg[c] != '0) ? ldc_reg[c] - 1'b1 : ldc_reg[c];
    assign ulc = (ulc_reg[c] != '0) ? ulc_reg[c] - 1'b1 : ulc_reg[c];

    always_comb
    begin
        for (int f = 0; f < FLOORS; f++)
        begin
            mabove[f] = (f > int'(cur));
            mbelow[f] = (f < int'(cur));
        end
        ra = req & mabove;
        rb = req & mbelow;
        dest_above = |(dst & mabove);
        dest_below = |(dst & mbelow);
        req_above  = |ra;
        req_below  = |rb;
        near_hi = '0;
        for (int f = FLOORS - 1; f >= 0; f--)
            if (ra[f])
                near_hi = FW'(f);
        near_lo = '0;
        for (int f = 0; f < FLOORS; f++)
            if (rb[f])
                near_lo = FW'(f);
    end

    always_comb
    begin
        logic [FW-1:0]    of;
        logic [DIR_W-1:0] od;
        logic             us, ds;
        bt_up = 1'b0;
        bt_dn = 1'b0;
        opp_up = 1'b0;
        opp_dn = 1'b0;
        for (int j = 0; j < CARS; j++)
        begin
            of = pos_reg[j];
            od = dir_reg[j];
            us = (od == DIR_UP) || (od == DIR_STOP);
            ds = (od == DIR_DN) || (od == DIR_STOP);
            if (j != int'(c))
            begin
                if (us && req_above && ((of > cur && of <= near_hi)
                    || (of == cur && j < int'(c))))
                    bt_up = 1'b1;
                if (ds && req_below && ((of < cur && of >= near_lo)
                    || (of == cur && j < int'(c))))
                    bt_dn = 1'b1;
                if (us && req_below && near_lo >= of
                    && (near_lo - of) < (cur - near_lo))
                    opp_up = 1'b1;
                if (ds && req_above && near_hi <= of
                    && (of - near_hi) < (near_hi - cur))
                    opp_dn = 1'b1;
            end
        end
    end

    always_comb
    begin
        d0 = dir_reg[c];
        if ((cur == FW'(FLOORS - 1) && d0 == DIR_UP) || (cur == '0 && d0 == DIR_DN))
            d0 = DIR_STOP;
        d_new   = d0;
        clr_dst = 1'b0;
        clr_up  = 1'b0;
        clr_dn  = 1'b0;
        arm_ul  = 1'b0;
        arm_ld  = 1'b0;
        priority if (dst[cur])
        begin
            clr_dst = 1'b1;
            arm_ul  = (ulc == '0);
        end
        else if (up_reg[cur] && d0 != DIR_DN)
        begin
            d_new  = DIR_UP;
            clr_up = 1'b1;
            arm_ld = (ldc == '0);
        end
        else if (dn_reg[cur] && d0 != DIR_UP)
        begin
            d_new  = DIR_DN;
            clr_dn = 1'b1;
            arm_ld = (ldc == '0);
        end
        else if (!dest_above && !req_above && !dest_below && !req_below)
            d_new = DIR_STOP;
        else if (dest_above && (d0 == DIR_STOP || d0 == DIR_UP))
            d_new = DIR_UP;
        else if (dest_below && (d0 == DIR_STOP || d0 == DIR_DN))
            d_new = DIR_DN;
        else if ((d0 == DIR_UP || d0 == DIR_STOP) && req_above && !bt_up && !opp_dn)
            d_new = DIR_UP;
        else if ((d0 == DIR_DN || d0 == DIR_STOP) && req_below && !bt_dn && !opp_up)
            d_new = DIR_DN;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg <= DWELL_TICKS_RST;
            up_reg <= '0;
            dn_reg <= '0;
            for (int i = 0; i < CARS; i++)
            begin
                dst_reg[i] <= '0;
                pos_reg[i] <= '0;
                dir_reg[i] <= DIR_STOP;
                ldc_reg[i] <= '0;
                ulc_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
                lt_reg <= cfg_data;
            if (cmd.event_apply)
            begin
                if (ev.kind == KIND_HALL && int'(ev.floor) < FLOORS)
                begin
                    if (ev.call_dir)
                        dn_reg[FW'(ev.floor)] <= 1'b1;
                    else
                        up_reg[FW'(ev.floor)] <= 1'b1;
                end
                if (ev.kind == KIND_DEST && int'(ev.floor) < FLOORS
                    && int'(ev.car) < CARS
                    && FW'(ev.floor) != pos_reg[AW'(ev.car)])
                begin
                    if (dir_reg[AW'(ev.car)] == DIR_STOP)
                        dir_reg[AW'(ev.car)] <= (FW'(ev.floor) < pos_reg[AW'(ev.car)])
                            ? DIR_DN : DIR_UP;
                    dst_reg[AW'(ev.car)][FW'(ev.floor)] <= 1'b1;
                end
            end
            if (cmd.decide)
            begin
                dir_reg[c] <= d_new;
                ldc_reg[c] <= arm_ld ? lt_reg : ldc;
                ulc_reg[c] <= arm_ul ? lt_reg : ulc;
                if (clr_dst)
                    dst_reg[c][cur] <= 1'b0;
                if (clr_up)
                    up_reg[cur] <= 1'b0;
                if (clr_dn)
                    dn_reg[cur] <= 1'b0;
            end
            if (cmd.move)
            begin
                for (int i = 0; i < CARS; i++)
                begin
                    if (ldc_reg[i] == '0 && ulc_reg[i] == '0)
                    begin
                        if (dir_reg[i] == DIR_UP && pos_reg[i] < FW'(FLOORS - 1))
                            pos_reg[i] <= pos_reg[i] + 1'b1;
                        else if (dir_reg[i] == DIR_DN && pos_reg[i] > '0)
                            pos_reg[i] <= pos_reg[i] - 1'b1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        st.car_index      = CAR_W'(car_sel);
        st.car_floor_out  = FLOOR_W'(pos_reg[c]);
        st.car_heading    = dir_reg[c];
        st.loading_busy   = (ldc_reg[c] != '0);
        st.unloading_busy = (ulc_reg[c] != '0);
        st.last_car       = (car_sel == CW'(CARS - 1));
    end

`ifndef SYNTH
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.move |=> int'(pos_reg[c]) < FLOORS) else $error("car beyond top floor");
    a_arm_one: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decide |-> !(arm_ld && arm_ul)) else $error("both timers armed");
    a_clr_one: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decide |-> $countones({clr_dst, clr_up, clr_dn}) <= 1)
        else $error("more than one clear");
`endif

endmodule

/* rtl/multi_car_elevator_dispatch_unit.sv */
// a tick decides each car in turn, then moves all cars, then returns CARS results
// one result per cycle while taken; hall calls and presses return no result
// a new event waits until the last result of a tick is taken; one shared decide unit
// reset: asynchronous active low; maps, floors, directions and timers clear, stop time 3
module multi_car_elevator_dispatch_unit
    import mced_pkg::*;
#(
    parameter int FLOORS = FLOORS_DEF,
    parameter int CARS   = CARS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [TIME_W-1:0] cfg_data,
    mced_if.sink              in_ch,
    mced_if.source            out_ch
);

    cmd_t                      cmd;
    logic [$clog2(CARS+1)-1:0] car_sel;

    mced_ctrl #(.CARS(CARS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_kind   (in_ch.data.kind),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .car_sel   (car_sel)
    );

    mced_dp #(.FLOORS(FLOORS), .CARS(CARS)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .ev       (in_ch.data),
        .cmd      (cmd),
        .car_sel  (car_sel),
        .st       (out_ch.data)
    );

endmodule

/* bench/tb_multi_car_elevator_dispatch_unit.sv */
`timescale 1ns / 1ps

module tb_multi_car_elevator_dispatch_unit;
    import mced_pkg::*;

    localparam int NF = FLOORS_DEF;
    localparam int NC = CARS_DEF;
    localparam int STALL_LIMIT = 20000;

    class status_board;
        st_t expected_q[$];
        int errors;
        logic [TIME_W-1:0] dwell_ticks;
        logic [NF-1:0] up_calls;
        logic [NF-1:0] down_calls;
        logic [NF-1:0] dest[NC];
        int pos[NC];
        logic [DIR_W-1:0] heading[NC];
        int load_cnt[NC];
        int unload_cnt[NC];

        function new();
            dwell_ticks = DWELL_TICKS_RST;
            up_calls = '0;
            down_calls = '0;
            errors = 0;
            for (int c = 0; c < NC; c++)
            begin
                dest[c] = '0;
                pos[c] = 0;
                heading[c] = DIR_STOP;
                load_cnt[c] = 0;
                unload_cnt[c] = 0;
            end
        endfunction

        function void pick_heading(int c);
            int cur;
            logic [DIR_W-1:0] d;
            logic [NF-1:0] calls;
            bit dest_hi, dest_lo, req_hi, req_lo;
            bit blk_up, blk_dn, opp_up, opp_dn, us, ds;
            int near_hi, near_lo, of;
            cur = pos[c];
            d = heading[c];
            dest_hi = 0; dest_lo = 0; req_hi = 0; req_lo = 0;
            blk_up = 0; blk_dn = 0; opp_up = 0; opp_dn = 0;
            near_hi = 0; near_lo = 0;
            if ((cur == NF - 1 && d == DIR_UP) || (cur == 0 && d == DIR_DN))
                d = DIR_STOP;
            heading[c] = d;
            if (dest[c][cur])
            begin
                dest[c][cur] = 1'b0;
                if (unload_cnt[c] == 0)
                    unload_cnt[c] = int'(dwell_ticks);
                return;
            end
            if (up_calls[cur] && d != DIR_DN)
            begin
                heading[c] = DIR_UP;
                up_calls[cur] = 1'b0;
                if (load_cnt[c] == 0)
                    load_cnt[c] = int'(dwell_ticks);
                return;
            end
            if (down_calls[cur] && d != DIR_UP)
            begin
                heading[c] = DIR_DN;
                down_calls[cur] = 1'b0;
                if (load_cnt[c] == 0)
                    load_cnt[c] = int'(dwell_ticks);
                return;
            end
            calls = up_calls | down_calls;
            for (int j = cur + 1; j < NF; j++)
            begin
                if (dest[c][j])
                    dest_hi = 1;
                if (calls[j])
                begin
                    if (!req_hi)
                        near_hi = j;
                    req_hi = 1;
                end
            end
            for (int j = cur - 1; j >= 0; j--)
            begin
                if (dest[c][j])
                    dest_lo = 1;
                if (calls[j])
                begin
                    if (!req_lo)
                        near_lo = j;
                    req_lo = 1;
                end
            end
            if (!dest_hi && !req_hi && !dest_lo && !req_lo)
            begin
                heading[c] = DIR_STOP;
                return;
            end
            if (dest_hi && (d == DIR_STOP || d == DIR_UP))
            begin
                heading[c] = DIR_UP;
                return;
            end
            if (dest_lo && (d == DIR_STOP || d == DIR_DN))
            begin
                heading[c] = DIR_DN;
                return;
            end
            for (int j = 0; j < NC; j++)
            begin
                if (j != c)
                begin
                    of = pos[j];
                    us = (heading[j] == DIR_UP || heading[j] == DIR_STOP);
                    ds = (heading[j] == DIR_DN || heading[j] == DIR_STOP);
                    if (us && req_hi && ((of > cur && of <= near_hi) || (of == cur && j < c)))
                        blk_up = 1;
                    if (ds && req_lo && ((of < cur && of >= near_lo) || (of == cur && j < c)))
                        blk_dn = 1;
                    if (us && req_lo && near_lo >= of && near_lo - of < cur - near_lo)
                        opp_up = 1;
                    if (ds && req_hi && near_hi <= of && of - near_hi < near_hi - cur)
                        opp_dn = 1;
                end
            end
            if ((d == DIR_UP || d == DIR_STOP) && req_hi && !blk_up && !opp_dn)
                heading[c] = DIR_UP;
            else if ((d == DIR_DN || d == DIR_STOP) && req_lo && !blk_dn && !opp_up)
                heading[c] = DIR_DN;
        endfunction

        function void note_event(ev_t e);
            st_t s;
            if (e.kind == KIND_HALL)
            begin
                if (e.call_dir)
                    down_calls[e.floor] = 1'b1;
                else
                    up_calls[e.floor] = 1'b1;
            end
            else if (e.kind == KIND_DEST)
            begin
                if (int'(e.floor) != pos[e.car])
                begin
                    if (heading[e.car] == DIR_STOP)
                        heading[e.car] = (int'(e.floor) < pos[e.car]) ? DIR_DN : DIR_UP;
                    dest[e.car][e.floor] = 1'b1;
                end
            end
            else if (e.kind == KIND_TICK)
            begin
                for (int c = 0; c < NC; c++)
                begin
                    if (load_cnt[c] != 0)
                        load_cnt[c]--;
                    if (unload_cnt[c] != 0)
                        unload_cnt[c]--;
                    pick_heading(c);
                end
                for (int c = 0; c < NC; c++)
                begin
                    if (load_cnt[c] == 0 && unload_cnt[c] == 0)
                    begin
                        if (heading[c] == DIR_UP && pos[c] < NF - 1)
                            pos[c]++;
                        else if (heading[c] == DIR_DN && pos[c] > 0)
                            pos[c]--;
                    end
                end
                for (int c = 0; c < NC; c++)
                begin
                    s.car_index = CAR_W'(c);
                    s.car_floor_out = FLOOR_W'(pos[c]);
                    s.car_heading = heading[c];
                    s.loading_busy = load_cnt[c] != 0;
                    s.unloading_busy = unload_cnt[c] != 0;
                    s.last_car = (c == NC - 1);
                    expected_q.push_back(s);
                end
            end
        endfunction

        function void check_status(st_t got);
            st_t w;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected status, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            w = expected_q.pop_front();
            if (got !== w)
            begin
                $display("%0t: status mismatch, expected %h, actual %h (car %0d flr %0d dir %0d)",
                    $time, w, got, w.car_index, w.car_floor_out, w.car_heading);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [TIME_W-1:0] cfg_data = '0;
    int send_idle = 0;
    int recv_idle = 0;
    int quiet_cycles = 0;
    int events_sent = 0;
    int ticks_sent = 0;
    status_board board;

    mced_if #(.T(ev_t)) in_ch ();
    mced_if #(.T(st_t)) out_ch ();

    multi_car_elevator_dispatch_unit uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    always #2 clk = ~clk;

    initial
    begin
        in_ch.valid = 0;
        in_ch.data = '0;
        out_ch.ready = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            board.check_status(out_ch.data);
        if (rst_n && ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout with %0d results pending", board.expected_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle);
    end

    task automatic send_event(ev_t e);
        while ($urandom_range(99) < send_idle)
        begin
            in_ch.valid <= 0;
            @(negedge clk);
        end
        in_ch.data <= e;
        in_ch.valid <= 1;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        board.note_event(e);
        events_sent++;
        if (e.kind == KIND_TICK)
            ticks_sent++;
        @(negedge clk);
    endtask

    task automatic send_fields(int k, int f, int d, int c);
        ev_t e;
        e.kind = KIND_W'(k);
        e.floor = FLOOR_W'(f);
        e.call_dir = 1'(d);
        e.car = CAR_W'(c);
        send_event(e);
    endtask

    task automatic send_ticks(int n);
        for (int i = 0; i < n; i++)
            send_fields(KIND_TICK, $urandom_range(15), $urandom_range(1), $urandom_range(3));
    endtask

    task automatic drain_and_set(int lt);
        in_ch.valid <= 0;
        while (board.expected_q.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
        cfg_data <= TIME_W'(lt);
        cfg_we <= 1;
        @(negedge clk);
        cfg_we <= 0;
        board.dwell_ticks = TIME_W'(lt);
    endtask

    task automatic random_phase(int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 45)
                send_ticks(1);
            else if (r < 70)
                send_fields(KIND_HALL, $urandom_range(15), $urandom_range(1), $urandom_range(3));
            else if (r < 95)
                send_fields(KIND_DEST, $urandom_range(15), $urandom_range(1), $urandom_range(3));
            else
                send_fields(3, $urandom_range(15), $urandom_range(1), $urandom_range(3));
        end
    endtask

    initial
    begin
        board = new();
        repeat (12) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);
        // directed: extremes, both call directions, calls at current floor, presses
        send_fields(KIND_HALL, 0, 0, 0);
        send_fields(KIND_HALL, 0, 1, 3);
        send_ticks(2);
        send_fields(KIND_DEST, 15, 1, 3);
        send_fields(KIND_DEST, 0, 0, 2);
        send_fields(KIND_HALL, 15, 1, 0);
        send_fields(KIND_HALL, 8, 0, 1);
        send_fields(KIND_DEST, 7, 0, 1);
        send_fields(3, 15, 1, 3);
        send_ticks(6);
        send_fields(KIND_HALL, 3, 1, 2);
        send_fields(KIND_DEST, 10, 1, 0);
        send_ticks(6);
        drain_and_set(0);
        send_fields(KIND_HALL, 5, 0, 0);
        send_fields(KIND_DEST, 2, 0, 2);
        send_ticks(4);

        drain_and_set(15);
        send_idle = 26; recv_idle = 86;
        random_phase(30);
        drain_and_set(1);
        send_idle = 86; recv_idle = 26;
        random_phase(30);
        drain_and_set(4);
        send_idle = 0; recv_idle = 0;
        random_phase(40);
        send_ticks(4);
        in_ch.valid <= 0;

        while (board.expected_q.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        $display("ran %0d events including %0d ticks over stop times 0, 1, 3, 4 and 15",
            events_sent, ticks_sent);
        if (board.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
